// ===== hw/rtl/pixel_input_quantizer_core_assert.svh =====
// Assertion macros for the pixel input quantizer core
`ifndef PIXEL_INPUT_QUANTIZER_CORE_ASSERT_SVH
`define PIXEL_INPUT_QUANTIZER_CORE_ASSERT_SVH

`ifndef SYNTH
`define PIQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel_input_quantizer_core: assertion failed");
`define PIQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel_input_quantizer_core: assertion failed");
`else
`define PIQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PIQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/piq_pkg.sv =====
// Shared types and constants of the pixel input quantizer
package piq_pkg;

	localparam int PixelW  = 8;
	localparam int ModeW   = 2;
	localparam int IbitsW  = 3;
	localparam int ScaleW  = 24;
	localparam int ZpW     = 9;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;
	localparam int ProdW   = PixelW + ScaleW;
	localparam int FracW   = 16;
	localparam int RndW    = ProdW - FracW + 1;
	localparam int SumW    = RndW + 2;

	typedef logic [ModeW-1:0] quant_mode_t;

	localparam quant_mode_t QM_FIXED    = 2'd0;
	localparam quant_mode_t QM_UNSIGNED = 2'd1;
	localparam quant_mode_t QM_SIGNED   = 2'd2;

	typedef logic [CfgIdxW-1:0] cfg_index_t;

	localparam cfg_index_t REG_QUANT_MODE   = 3'd0;
	localparam cfg_index_t REG_INTEGER_BITS = 3'd1;
	localparam cfg_index_t REG_COMB_SCALE   = 3'd2;
	localparam cfg_index_t REG_INPUT_OFFSET = 3'd3;
	localparam cfg_index_t REG_OUTPUT_ZP    = 3'd4;

	localparam logic [ScaleW-1:0] SCALE_ONE = 24'd65536;
	localparam logic [ProdW:0]    ROUND_HALF = 33'd32768;

	localparam logic signed [SumW-1:0] UNSIGNED_MIN = 19'sd0;
	localparam logic signed [SumW-1:0] UNSIGNED_MAX = 19'sd255;
	localparam logic signed [SumW-1:0] SIGNED_MIN   = -19'sd128;
	localparam logic signed [SumW-1:0] SIGNED_MAX   = 19'sd127;

endpackage

// ===== hw/rtl/pixel_input_quantizer_core.sv =====
// Pixel input quantizer: fixed-point and affine int8/uint8 quantization of 8-bit pixels
// A taken start passes the input and multiply registers; done comes from the result register.
// Throughput: one pixel per cycle; busy stays low, the input register, multiply
// register and result register form a three-stage pipeline.
// Reset: configuration returns to its defaults and pipeline valids clear.
// Each result shows for one cycle under done; the receiver cannot stall.
`include "pixel_input_quantizer_core_assert.svh"

module pixel_input_quantizer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [piq_pkg::PixelW-1:0]      pixel,
	output logic                            done,
	output logic [piq_pkg::PixelW-1:0]      quantized_pixel,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [piq_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [piq_pkg::CfgDataW-1:0]    cfg_data
);

	piq_pkg::quant_mode_t                quant_mode_q;
	logic [piq_pkg::IbitsW-1:0]          integer_bits_q;
	logic [piq_pkg::ScaleW-1:0]          combined_scale_q;
	logic [piq_pkg::PixelW-1:0]          input_offset_q;
	logic [piq_pkg::ZpW-1:0]             output_zp_q;

	logic                                valid_s1;
	logic [piq_pkg::PixelW-1:0]          pixel_s1;
	logic                                valid_s2;
	logic [piq_pkg::ProdW-1:0]           prod_s2;
	logic                                neg_s2;
	logic [piq_pkg::PixelW-1:0]          fix_s2;
	logic                                done_q;
	logic [piq_pkg::PixelW-1:0]          quantized_pixel_q;

	logic signed [piq_pkg::PixelW:0]     diff;
	logic [piq_pkg::PixelW:0]            mag9;
	logic [piq_pkg::ProdW-1:0]           prod_c;
	logic [piq_pkg::PixelW:0]            fix_sum;
	logic [piq_pkg::PixelW:0]            fix_shr;
	logic [piq_pkg::PixelW-1:0]          fix_c;

	logic [piq_pkg::ProdW:0]             rnd_sum;
	logic [piq_pkg::RndW-1:0]            rnd;
	logic signed [piq_pkg::SumW-1:0]     rnd_s;
	logic signed [piq_pkg::SumW-1:0]     aff_sum;
	logic signed [piq_pkg::SumW-1:0]     lo;
	logic signed [piq_pkg::SumW-1:0]     hi;
	logic signed [piq_pkg::SumW-1:0]     clamped;
	logic [piq_pkg::PixelW-1:0]          result_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign quantized_pixel = quantized_pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_mode_q     <= piq_pkg::QM_UNSIGNED;
			integer_bits_q   <= '0;
			combined_scale_q <= piq_pkg::SCALE_ONE;
			input_offset_q   <= '0;
			output_zp_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				piq_pkg::REG_QUANT_MODE:   quant_mode_q     <= cfg_data[piq_pkg::ModeW-1:0];
				piq_pkg::REG_INTEGER_BITS: integer_bits_q   <= cfg_data[piq_pkg::IbitsW-1:0];
				piq_pkg::REG_COMB_SCALE:   combined_scale_q <= cfg_data[piq_pkg::ScaleW-1:0];
				piq_pkg::REG_INPUT_OFFSET: input_offset_q   <= cfg_data[piq_pkg::PixelW-1:0];
				piq_pkg::REG_OUTPUT_ZP:    output_zp_q      <= cfg_data[piq_pkg::ZpW-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: capture the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pixel_s1 <= pixel;
		end
	end

	// stage 2: offset, magnitude, multiply; fixed-point shift
	always_comb begin
		diff    = $signed({1'b0, pixel_s1}) - $signed({1'b0, input_offset_q});
		mag9    = diff[piq_pkg::PixelW] ? 9'(-diff) : 9'(diff);
		prod_c  = piq_pkg::ProdW'(mag9[piq_pkg::PixelW-1:0]) *
			piq_pkg::ProdW'(combined_scale_q);
		fix_sum = {1'b0, pixel_s1} + (9'd1 << integer_bits_q);
		fix_shr = fix_sum >> (4'(integer_bits_q) + 4'd1);
		fix_c   = fix_shr[piq_pkg::PixelW] ? {piq_pkg::PixelW{1'b1}} :
			fix_shr[piq_pkg::PixelW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= prod_c;
			neg_s2  <= diff[piq_pkg::PixelW];
			fix_s2  <= fix_c;
		end
	end

	// stage 3: round half away from zero, add zero point, clamp
	always_comb begin
		rnd_sum = {1'b0, prod_s2} + piq_pkg::ROUND_HALF;
		rnd     = rnd_sum[piq_pkg::ProdW:piq_pkg::FracW];
		rnd_s   = neg_s2 ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
		aff_sum = $signed({{(piq_pkg::SumW-piq_pkg::ZpW){output_zp_q[piq_pkg::ZpW-1]}},
			output_zp_q}) + rnd_s;
		// high mode bit selects the signed range
		lo = quant_mode_q[1] ? piq_pkg::SIGNED_MIN : piq_pkg::UNSIGNED_MIN;
		hi = quant_mode_q[1] ? piq_pkg::SIGNED_MAX : piq_pkg::UNSIGNED_MAX;
		if (aff_sum < lo) begin
			clamped = lo;
		end else if (aff_sum > hi) begin
			clamped = hi;
		end else begin
			clamped = aff_sum;
		end
		result_c = (quant_mode_q == piq_pkg::QM_FIXED) ? fix_s2 :
			clamped[piq_pkg::PixelW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			quantized_pixel_q <= result_c;
		end
	end

	`PIQ_ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##3 done)
	`PIQ_ASSERT_IMP(a_no_spurious, clk, arst_n, !start, ##3 !done)
	`PIQ_ASSERT_NXT(a_stage_order, clk, arst_n, valid_s1, valid_s2)
	`PIQ_ASSERT_IMP(a_identity, clk, arst_n,
		done && quant_mode_q == piq_pkg::QM_UNSIGNED && output_zp_q == '0 &&
		combined_scale_q == piq_pkg::SCALE_ONE && input_offset_q == '0,
		quantized_pixel == $past(pixel, 3))
	`PIQ_ASSERT_IMP(a_fixed_range, clk, arst_n,
		done && quant_mode_q == piq_pkg::QM_FIXED && integer_bits_q == 3'd7,
		quantized_pixel <= 8'd1)

endmodule
